// File: rtl/core/per_key_chatter_filter_defines.svh
// Assertion macros shared by the chatter filter RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef PER_KEY_CHATTER_FILTER_DEFINES_SVH
`define PER_KEY_CHATTER_FILTER_DEFINES_SVH

// same-cycle implication
`define PKCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PKCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pkcf_pkg.sv
// Shared constants for the per-key chatter filter.
// No dependencies.
package pkcf_pkg;

  localparam int NUM_KEYS_DEF  = 256;
  localparam int TIME_BITS_DEF = 32;

  localparam int KEY_W      = 8;
  localparam int EVT_W      = 2;
  localparam int STAMP_W    = 32;
  localparam int KIND_W     = 3;
  localparam int INTERVAL_W = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_DOWN = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UP   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd4;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS       = 4'd1;

endpackage

// File: rtl/core/pkcf_in_if.sv
// Input event channel: valid/ready plus one keyboard event word.
// Depends on pkcf_pkg.
interface pkcf_in_if;
  import pkcf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KEY_W-1:0]     key_code;
  logic [EVT_W-1:0]     event_kind;
  logic [STAMP_W-1:0]   timestamp;
  logic                 is_action;

  modport source (output valid, key_code, event_kind, timestamp, is_action, input ready);
  modport sink   (input valid, key_code, event_kind, timestamp, is_action, output ready);
endinterface

// File: rtl/core/pkcf_out_if.sv
// Result channel: valid/ready plus the pass/swallow decision.
// No dependencies.
interface pkcf_out_if;
  logic valid;
  logic ready;
  logic pass_event;

  modport source (output valid, pass_event, input ready);
  modport sink   (input valid, pass_event, output ready);
endinterface

// File: rtl/core/pkcf_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on pkcf_pkg.
interface pkcf_cfg_if;
  import pkcf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/core/per_key_chatter_filter.sv
// Per-key chatter filter top level: key table RAM, compare stage, output register.
// Depends on pkcf_pkg, pkcf_in_if, pkcf_out_if, pkcf_cfg_if, pkcf_ram and the defines header.
//
// Takes one event word per clock while the output is not stalled and returns one
// pass/swallow word per event, in order. An accepted event reads its key's entry from
// the table RAM at the accept edge; in the next cycle stage 1 compares the time since the
// key's last key-down against min_interval_ms, and when stage 1 advances a filtered event
// writes its updated entry back and the decision lands in the output register. A
// write-back to the same key as the event being read in that cycle is forwarded, so
// repeated events on one key still run one per cycle while the output is not stalled.
// The table starts cleared straight out of reset through per-key valid flags: no clearing
// pass. The output register keeps taking words while a result is held, as long as out
// ready is high; the cfg port is always ready.
module per_key_chatter_filter #(
  parameter int NUM_KEYS  = pkcf_pkg::NUM_KEYS_DEF,
  parameter int TIME_BITS = pkcf_pkg::TIME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pkcf_in_if.sink      in_ch,
  pkcf_out_if.source   out_ch,
  pkcf_cfg_if.sink     cfg_ch
);
  import pkcf_pkg::*;

`include "per_key_chatter_filter_defines.svh"

  localparam int IDX_W   = $clog2(NUM_KEYS);
  localparam int ENTRY_W = KIND_W + TIME_BITS;
  localparam int CMP_W   = (TIME_BITS > INTERVAL_W) ? TIME_BITS : INTERVAL_W;

  // config
  logic [INTERVAL_W-1:0] min_interval_r;
  logic                  bypass_r;

  // stage 1
  logic                 s1_valid_r;
  logic [KEY_W-1:0]     s1_key_r;
  logic [EVT_W-1:0]     s1_kind_r;
  logic [TIME_BITS-1:0] s1_time_r;
  logic                 s1_act_r;
  logic                 s1_fwd_r;
  logic [ENTRY_W-1:0]   s1_fwd_data_r;

  logic                 out_valid_r;
  logic                 out_pass_r;

  logic [NUM_KEYS-1:0]  valid_r;

  logic                 out_free;
  logic                 s1_adv;
  logic                 in_ready;
  logic                 accept;
  logic [IDX_W-1:0]     in_idx;
  logic [IDX_W-1:0]     s1_idx;
  logic                 s1_in_range;
  logic                 s1_filt;
  logic                 s1_is_down;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [ENTRY_W-1:0]   cur_entry;
  logic [KIND_W-1:0]    cur_kind;
  logic [TIME_BITS-1:0] cur_time;
  logic [TIME_BITS-1:0] diff;
  logic                 s1_pass;
  logic                 ram_we;
  logic [ENTRY_W-1:0]   ram_wdata;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign accept   = in_ch.valid && in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.pass_event = out_pass_r;

  assign in_idx = in_ch.key_code[IDX_W-1:0];
  assign s1_idx = s1_key_r[IDX_W-1:0];

  always_comb begin
    s1_in_range = ({1'b0, s1_key_r} < (KEY_W + 1)'(NUM_KEYS));
    s1_filt     = !bypass_r && s1_act_r && s1_in_range;
    s1_is_down  = ({1'b0, s1_kind_r} == KIND_DOWN);
    if (s1_fwd_r) begin
      cur_entry = s1_fwd_data_r;
    end else if (valid_r[s1_idx]) begin
      cur_entry = ram_rdata;
    end else begin
      cur_entry = {KIND_NONE, {TIME_BITS{1'b0}}};
    end
    cur_kind  = cur_entry[ENTRY_W-1:TIME_BITS];
    cur_time  = cur_entry[TIME_BITS-1:0];
    diff      = s1_time_r - cur_time;
    s1_pass   = !(s1_filt && s1_is_down && (cur_kind == KIND_UP) &&
                  (CMP_W'(diff) < CMP_W'(min_interval_r)));
    ram_we    = s1_adv && s1_filt;
    ram_wdata = {{1'b0, s1_kind_r}, (s1_is_down ? s1_time_r : cur_time)};
  end

  pkcf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_KEYS),
    .ADDR_W(IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_idx),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(in_idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= INTERVAL_RESET;
      bypass_r       <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_MIN_INTERVAL: min_interval_r <= cfg_ch.wdata[INTERVAL_W-1:0];
        REG_BYPASS:       bypass_r       <= cfg_ch.wdata[0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[s1_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (accept) begin
        s1_fwd_r <= ram_we && (s1_idx == in_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_r      <= in_ch.key_code;
      s1_kind_r     <= in_ch.event_kind;
      s1_time_r     <= in_ch.timestamp[TIME_BITS-1:0];
      s1_act_r      <= in_ch.is_action;
      s1_fwd_data_r <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pass_r <= s1_pass;
    end
  end

  `PKCF_ASSERT_NOW(a_fwd_entry_written, s1_valid_r && s1_fwd_r && s1_in_range,
                   valid_r[s1_idx], "forwarded entry not marked written")
  `PKCF_ASSERT_NEXT(a_unfiltered_passes, s1_adv && !s1_filt,
                    out_valid_r && out_pass_r, "unfiltered word swallowed")
  `PKCF_ASSERT_NOW(a_stall_only_when_full, !in_ready,
                   s1_valid_r && out_valid_r && !out_ch.ready, "input stalled with room in pipe")
  `PKCF_ASSERT_NOW(a_out_from_stage1, $rose(out_valid_r),
                   $past(s1_valid_r), "result without stage 1 word")

endmodule

// File: rtl/core/pkcf_ram.sv
// Generic single-write, single-read synchronous RAM, registered read (old data on collision).
// No dependencies.
module pkcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
